// ----- hw/rtl/hbi_pkg.sv -----
// shared types, constants and rounding helper for the halfband interpolator
package hbi_pkg;

	localparam int HALF_TAPS    = 7;
	localparam int HIST_LEN     = 2 * HALF_TAPS - 1;
	localparam int CENTER_DELAY = HALF_TAPS - 1;
	localparam int NUM_TAP_REGS = 7;
	localparam int NUM_PSUM     = (HALF_TAPS + 1) / 2;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 18;
	localparam int PAIR_W    = SAMPLE_W + 1;
	localparam int PROD_W    = PAIR_W + COEF_W;
	localparam int CPROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W     = PROD_W + $clog2(HALF_TAPS) + 1;
	localparam int FRAC_W    = 16;
	localparam int SHIFT_W   = ACC_W - FRAC_W;
	localparam int CFG_IDX_W = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAP_FIRST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = CFG_IDX_W'(NUM_TAP_REGS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef coef_t coef_arr_t [HALF_TAPS];

	localparam coef_t COEF_CENTER_RST = COEF_W'(65536);
	localparam acc_t  ROUND_HALF      = ACC_W'(1 << (FRAC_W - 1));
	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// acc already carries the half-lsb rounding offset; floor shift then clamp
	function automatic sample_t round_sat(input acc_t acc);
		logic [SHIFT_W-1:0]         sh;
		logic [SHIFT_W-SAMPLE_W:0]  hi;
		sh = acc[ACC_W-1:FRAC_W];
		hi = sh[SHIFT_W-1:SAMPLE_W-1];
		if ((hi == '0) || (hi == '1)) begin
			round_sat = sample_t'(sh[SAMPLE_W-1:0]);
		end else if (sh[SHIFT_W-1]) begin
			round_sat = SAT_MIN;
		end else begin
			round_sat = SAT_MAX;
		end
	endfunction

endpackage

// ----- hw/rtl/hbi_coef_regs.sv -----
// coefficient register file written through the configuration port
module hbi_coef_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbi_pkg::COEF_W-1:0]     cfg_wdata,
	output hbi_pkg::coef_arr_t             tap_coef,
	output hbi_pkg::coef_t                 center_coef
);
	import hbi_pkg::*;

	coef_t center_q;

	genvar i;
	generate
		for (i = 0; i < HALF_TAPS; i++) begin : g_tap
			if (i < NUM_TAP_REGS) begin : g_reg
				coef_t tap_q;
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						tap_q <= '0;
					end else if (cfg_we && (cfg_index == REG_TAP_FIRST + CFG_IDX_W'(i))) begin
						tap_q <= coef_t'(cfg_wdata);
					end
				end
				assign tap_coef[i] = tap_q;
			end else begin : g_zero
				// taps past the register list stay zero
				assign tap_coef[i] = '0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= COEF_CENTER_RST;
		end else if (cfg_we && (cfg_index == REG_CENTER)) begin
			center_q <= coef_t'(cfg_wdata);
		end
	end

	assign center_coef = center_q;

endmodule

// ----- hw/rtl/halfband_polyphase_upsampler.sv -----
// top level: 2x halfband polyphase interpolator with stream ports
//
// Every input sample gives two output samples on the master side: first the
// upper branch (folded symmetric FIR, 2*HALF_TAPS taps, tlast low), then the
// lower branch (center_coef times the sample delayed by HALF_TAPS-1, tlast
// high). Samples are 24-bit two's complement, coefficients Q2.16; sums are
// exact, rounded half up and saturated to 24 bits. The single result port
// moves one output item per cycle unless stalled; each input makes two, and
// input is taken only when the output is empty or its lower item leaves.
// Registered stages: pair-add, multiply, partial sums, final sum with round
// and saturate. Stalls on the master side hold the whole pipeline. Coefficient
// registers are to be written by cfg_we/cfg_index/cfg_wdata only while the
// block is idle; the block does not enforce it; index 0..6 are the tap
// coefficients from the outermost pair inward, index 7 is the center gain
// (reset 1.0), others are ignored. The sample history is cleared by reset.
module halfband_polyphase_upsampler (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hbi_pkg::SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hbi_pkg::SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
	output logic                           m_tlast,   // second_of_pair
	// configuration write port
	input  logic                           cfg_we,
	input  logic [hbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbi_pkg::COEF_W-1:0]     cfg_wdata
);
	import hbi_pkg::*;

	coef_arr_t tap_coef;
	coef_t     center_coef;

	hbi_coef_regs u_coef (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.tap_coef    (tap_coef),
		.center_coef (center_coef)
	);

	// sample history: hist_q[0] is x[n-1]
	sample_t hist_q [HIST_LEN];
	sample_t win [HIST_LEN+1];

	// pipeline payload
	logic signed [PAIR_W-1:0]  pair_s1 [HALF_TAPS];
	sample_t                   center_s1;
	logic signed [PROD_W-1:0]  prod_s2 [HALF_TAPS];
	logic signed [CPROD_W-1:0] cprod_s2;
	acc_t                      psum_s3 [NUM_PSUM];
	acc_t                      cacc_s3;
	acc_t                      acc_sum;
	sample_t                   upper_q;
	sample_t                   lower_q;

	// pipeline control
	logic v1_q, v2_q, v3_q;
	logic out_valid_q;
	logic phase_q;      // 0: upper result showing, 1: lower result showing
	logic en;
	logic accept;

	// the pipe moves when the output pair is empty or its last item leaves
	assign en       = !out_valid_q || (m_tready && phase_q);
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// window: new sample followed by the history
	always_comb begin
		win[0] = sample_t'(s_tdata);
		for (int j = 1; j <= HIST_LEN; j++) begin
			win[j] = hist_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HIST_LEN; j++) begin
				hist_q[j] <= '0;
			end
		end else if (accept) begin
			for (int j = 0; j < HIST_LEN; j++) begin
				hist_q[j] <= win[j];
			end
		end
	end

	// stage 1: fold symmetric sample pairs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < HALF_TAPS; k++) begin
				pair_s1[k] <= PAIR_W'(win[k]) + PAIR_W'(win[HIST_LEN-k]);
			end
			center_s1 <= win[CENTER_DELAY];
		end
	end

	// stage 2: one multiply per folded pair, plus the center product
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < HALF_TAPS; k++) begin
				prod_s2[k] <= PROD_W'(pair_s1[k]) * PROD_W'(tap_coef[k]);
			end
			cprod_s2 <= CPROD_W'(center_s1) * CPROD_W'(center_coef);
		end
	end

	// stage 3: add products two at a time; rounding offset rides in the first sum
	genvar g;
	generate
		for (g = 0; g < NUM_PSUM; g++) begin : g_psum
			acc_t lo_term;
			acc_t hi_term;
			assign lo_term = (g == 0) ? (ACC_W'(prod_s2[2*g]) + ROUND_HALF)
			                          : ACC_W'(prod_s2[2*g]);
			if (2*g + 1 < HALF_TAPS) begin : g_two
				assign hi_term = ACC_W'(prod_s2[2*g+1]);
			end else begin : g_one
				assign hi_term = '0;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					psum_s3[g] <= lo_term + hi_term;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			cacc_s3 <= ACC_W'(cprod_s2) + ROUND_HALF;
		end
	end

	// final sum feeding the round and clamp
	always_comb begin
		acc_sum = '0;
		for (int j = 0; j < NUM_PSUM; j++) begin
			acc_sum = acc_sum + psum_s3[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upper_q <= round_sat(acc_sum);
			lower_q <= round_sat(cacc_s3);
		end
	end

	// valid bits and the output pair sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (en) begin
			v1_q        <= s_tvalid;
			v2_q        <= v1_q;
			v3_q        <= v2_q;
			out_valid_q <= v3_q;
			phase_q     <= 1'b0;
		end else if (m_tready && out_valid_q && !phase_q) begin
			// upper item taken, lower item goes next
			phase_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = phase_q ? lower_q : upper_q;
	assign m_tlast  = phase_q;

endmodule

// ----- hw/rtl/hbi_checker.sv -----
// port-level checks for the halfband interpolator, bound to the top level
module hbi_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hbi_pkg::SAMPLE_W-1:0]   m_tdata,
	input logic                           m_tlast
);

	// a first-of-pair item is always followed by its second
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
		else $error("upper item not followed by lower item");

	// no new input while the upper item of a pair is pending
	a_no_accept_mid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input taken while a pair is half delivered");

	// finishing a pair frees the input side in the same cycle
	a_ready_on_pair_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |-> s_tready)
		else $error("input not ready when a pair completes");

	// stalled output holds its item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output item changed under stall");

	// the input handshake is only seen with no upper item waiting
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !(m_tvalid && !m_tlast))
		else $error("input accepted with an upper item still waiting");

endmodule

bind halfband_polyphase_upsampler hbi_checker u_hbi_checker (.*);
